>>> hdl/deadline_timer_queue_defines.svh
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; the including module provides clk and arst_n.
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DTQ_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dtq_pkg.sv
// Package for the deadline timer queue: item types, codes, slot layout.
// No dependencies.
package dtq_pkg;

	localparam int DTQ_SLOTS = 32;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		KIND_FIRED        = 3'd0,
		KIND_NEW_DEADLINE = 3'd1,
		KIND_NO_CHANGE    = 3'd2,
		KIND_EMPTY        = 3'd3,
		KIND_DROPPED      = 3'd4
	} result_kind_t;

	typedef struct packed {
		op_t         operation;
		logic [15:0] timer_handle;
		logic [47:0] expiry_time;
		logic [31:0] repeat_interval;
		logic [47:0] current_time;
	} req_item_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [15:0]  fired_handle;
		logic [47:0]  next_deadline;
		logic         last_result;
	} rsp_item_t;

	// One table entry as stored in the slot memory
	typedef struct packed {
		logic        valid;
		logic [47:0] expiry;
		logic [31:0] interval;
		logic [15:0] handle;
	} slot_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE_ADD,
		S_FIRE,
		S_LAST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MODE_ADD,
		MODE_FIRE,
		MODE_REARM
	} mode_t;

endpackage

>>> hdl/deadline_timer_queue.sv
// Deadline timer queue: TIMER_SLOTS timers held in one slot memory, scanned by a
// single compare unit. After reset a clearing pass over every slot runs before
// the first item is taken. An add item takes one pass to find the lowest free
// slot. A tick makes one memory pass per fired timer to pick the next one in
// expiry order, one pass that finds nothing more, and one pass that re-arms or
// removes the fired timers while finding the earliest deadline. Each pass reads
// one slot a cycle through the memory's single read port. One item is worked at
// a time; the final result may wait in the output register while the next item
// is accepted. Output stalls hold the sequencer in its result states.
// Depends on dtq_pkg and deadline_timer_queue_defines.svh.
`include "deadline_timer_queue_defines.svh"

module deadline_timer_queue #(
	parameter int TIMER_SLOTS = dtq_pkg::DTQ_SLOTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  dtq_pkg::req_item_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output dtq_pkg::rsp_item_t rsp
);
	import dtq_pkg::*;

	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

	// Slot memory
	slot_t mem [TIMER_SLOTS];

	state_t        state_q, state_nx;
	mode_t         mode_q;
	logic [IW-1:0] scan_idx_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	slot_t         rd_s1;

	req_item_t     item_q;
	logic          best_found_q;
	logic [IW-1:0] best_idx_q;
	logic [47:0]   best_exp_q;
	logic [15:0]   best_handle_q;
	logic          last_vld_q;
	logic [47:0]   last_exp_q;
	logic [IW-1:0] last_idx_q;
	logic [47:0]   earliest_q;
	logic          nonempty_q;
	logic          rsp_valid_q;
	rsp_item_t     rsp_q;

	logic          out_free;
	logic          emit_c;
	rsp_item_t     rsp_next;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	slot_t         mem_wd;
	logic          req_acc;
	logic          scan_wrap;
	logic          add_changed;

	// Shared compare unit on the slot just read
	logic          expired_c;
	logic          after_last_c;
	logic [48:0]   rearm_sum;
	logic [47:0]   rearm_exp;
	logic          keep_c;
	logic [47:0]   key_c;
	logic          take_c;

	assign out_free    = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == S_IDLE);
	assign req_acc     = req_valid && req_ready;
	assign scan_wrap   = (scan_idx_q == LAST_IDX);
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;
	assign add_changed = !nonempty_q || (item_q.expiry_time < earliest_q);

	always_comb begin
		expired_c    = rd_s1.valid && (rd_s1.expiry < item_q.current_time);
		after_last_c = !last_vld_q || (rd_s1.expiry > last_exp_q) ||
			((rd_s1.expiry == last_exp_q) && (idx_s1 > last_idx_q));
		rearm_sum    = {1'b0, item_q.current_time} + {17'd0, rd_s1.interval};
		rearm_exp    = rearm_sum[48] ? {48{1'b1}} : rearm_sum[47:0];
		keep_c       = rd_s1.valid && !(expired_c && (rd_s1.interval == 32'd0));
		key_c        = expired_c ? rearm_exp : rd_s1.expiry;
		take_c       = 1'b0;
		case (mode_q)
			MODE_ADD: begin
				take_c = !rd_s1.valid && !best_found_q;
			end
			MODE_FIRE: begin
				key_c  = rd_s1.expiry;
				take_c = expired_c && after_last_c &&
					(!best_found_q || (rd_s1.expiry < best_exp_q));
			end
			MODE_REARM: begin
				take_c = keep_c && (!best_found_q || (key_c < best_exp_q));
			end
			default: begin
				take_c = 1'b0;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (scan_wrap) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (req_acc) state_nx = S_SCAN;
			end
			S_SCAN: begin
				if (scan_wrap) state_nx = S_DRAIN;
			end
			S_DRAIN: begin
				case (mode_q)
					MODE_ADD:   state_nx = S_DONE_ADD;
					MODE_FIRE:  state_nx = S_FIRE;
					MODE_REARM: state_nx = S_LAST_OUT;
					default:    state_nx = S_IDLE;
				endcase
			end
			S_DONE_ADD: begin
				if (out_free) state_nx = S_IDLE;
			end
			S_FIRE: begin
				if (!best_found_q || out_free) state_nx = S_SCAN;
			end
			S_LAST_OUT: begin
				if (out_free) state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: memory writes and result emission
	always_comb begin
		mem_we   = 1'b0;
		mem_wa   = scan_idx_q;
		mem_wd   = '0;
		emit_c   = 1'b0;
		rsp_next = '{result_kind: KIND_FIRED, fired_handle: 16'd0,
			next_deadline: 48'd0, last_result: 1'b1};
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCAN, S_DRAIN: begin
				// fired timers are re-armed or dropped as the final pass sees them
				if (mode_q == MODE_REARM && vld_s1 && expired_c) begin
					mem_we          = 1'b1;
					mem_wa          = idx_s1;
					mem_wd          = rd_s1;
					mem_wd.valid    = keep_c;
					mem_wd.expiry   = rearm_exp;
				end
			end
			S_DONE_ADD: begin
				if (out_free) begin
					emit_c = 1'b1;
					if (!best_found_q) begin
						rsp_next.result_kind = KIND_DROPPED;
					end else begin
						mem_we = 1'b1;
						mem_wa = best_idx_q;
						mem_wd = '{valid: 1'b1, expiry: item_q.expiry_time,
							interval: item_q.repeat_interval, handle: item_q.timer_handle};
						if (add_changed) begin
							rsp_next.result_kind   = KIND_NEW_DEADLINE;
							rsp_next.next_deadline = item_q.expiry_time;
						end else begin
							rsp_next.result_kind = KIND_NO_CHANGE;
						end
					end
				end
			end
			S_FIRE: begin
				if (best_found_q && out_free) begin
					emit_c                = 1'b1;
					rsp_next.result_kind  = KIND_FIRED;
					rsp_next.fired_handle = best_handle_q;
					rsp_next.last_result  = 1'b0;
				end
			end
			S_LAST_OUT: begin
				if (out_free) begin
					emit_c = 1'b1;
					if (best_found_q) begin
						rsp_next.result_kind   = KIND_NEW_DEADLINE;
						rsp_next.next_deadline = best_exp_q;
					end else begin
						rsp_next.result_kind = KIND_EMPTY;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[scan_idx_q];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			mode_q       <= MODE_ADD;
			scan_idx_q   <= '0;
			vld_s1       <= 1'b0;
			best_found_q <= 1'b0;
			last_vld_q   <= 1'b0;
			nonempty_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= (state_q == S_SCAN);

			// scan address walks the table in clearing and scan passes
			if (state_q == S_CLEAR || state_q == S_SCAN) begin
				scan_idx_q <= scan_wrap ? '0 : scan_idx_q + 1'b1;
			end

			if (vld_s1 && take_c) best_found_q <= 1'b1;

			if (req_acc) begin
				mode_q       <= (req.operation == OP_TICK) ? MODE_FIRE : MODE_ADD;
				scan_idx_q   <= '0;
				best_found_q <= 1'b0;
				last_vld_q   <= 1'b0;
			end

			if (state_q == S_FIRE) begin
				if (!best_found_q) begin
					mode_q <= MODE_REARM;
				end else if (out_free) begin
					last_vld_q   <= 1'b1;
					best_found_q <= 1'b0;
				end
			end

			if (state_q == S_DONE_ADD && out_free && best_found_q) nonempty_q <= 1'b1;
			if (state_q == S_LAST_OUT && out_free) nonempty_q <= best_found_q;

			// output register
			if (emit_c) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_idx_q;
		if (req_acc) item_q <= req;
		if (vld_s1 && take_c) begin
			best_idx_q    <= idx_s1;
			best_exp_q    <= key_c;
			best_handle_q <= rd_s1.handle;
		end
		if (state_q == S_FIRE && best_found_q && out_free) begin
			last_exp_q <= best_exp_q;
			last_idx_q <= best_idx_q;
		end
		if (state_q == S_DONE_ADD && out_free && best_found_q && add_changed) begin
			earliest_q <= item_q.expiry_time;
		end
		if (state_q == S_LAST_OUT && out_free) earliest_q <= best_exp_q;
		if (emit_c) rsp_q <= rsp_next;
	end

	// Checks
	`DTQ_ASSERT(a_write_when_allowed, mem_we,
		state_q == S_CLEAR || state_q == S_DONE_ADD || mode_q == MODE_REARM,
		"slot memory written outside clear, add or re-arm")
	`DTQ_ASSERT(a_fire_order, state_q == S_FIRE && best_found_q && last_vld_q,
		best_exp_q >= last_exp_q, "timers fired out of expiry order")
	`DTQ_ASSERT(a_accept_quiet, req_acc, !vld_s1,
		"item accepted while a scan is still in flight")
	`DTQ_ASSERT_NEXT(a_last_ends_item, emit_c && rsp_next.last_result,
		state_q == S_IDLE, "final result not followed by idle")

endmodule
